>>> rtl/png_chunk_envelope_checker_defines.svh
// Assertion macros used by the assertion checker of the PNG chunk envelope checker.
`ifndef PNG_CHUNK_ENVELOPE_CHECKER_DEFINES_SVH
`define PNG_CHUNK_ENVELOPE_CHECKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("png chunk checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define PCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("png chunk checker: next-cycle property failed");

`endif

>>> rtl/pngce_pkg.sv
// Package with the types, codes and constants of the PNG chunk envelope checker.
`default_nettype none
package pngce_pkg;

	typedef enum logic [2:0] {
		PH_SIG  = 3'd0,
		PH_HEAD = 3'd1,
		PH_SKIP = 3'd2,
		PH_DONE = 3'd3,
		PH_ERR  = 3'd4
	} phase_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_SIG   = 3'd1;
	localparam logic [2:0] ST_TRUNC_ENV = 3'd2;
	localparam logic [2:0] ST_TOO_MANY  = 3'd3;
	localparam logic [2:0] ST_TRUNC_PAY = 3'd4;
	localparam logic [2:0] ST_IEND_BAD  = 3'd5;
	localparam logic [2:0] ST_IEND_MISS = 3'd6;

	localparam logic [31:0] MAX_CHUNKS_RESET = 32'd1024;
	localparam logic [31:0] TAG_IEND = {8'h49, 8'h45, 8'h4E, 8'h44};

	localparam logic [2:0] SIG_LAST_POS  = 3'd7;
	localparam logic [3:0] HDR_LEN_END   = 4'd4;
	localparam logic [3:0] HDR_TAG_END   = 4'd8;
	localparam logic [3:0] HDR_LAST_POS  = 4'd11;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] chunk_count;
	} result_t;

	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h89;
			3'd1: b = 8'h50;
			3'd2: b = 8'h4E;
			3'd3: b = 8'h47;
			3'd4: b = 8'h0D;
			3'd5: b = 8'h0A;
			3'd6: b = 8'h1A;
			3'd7: b = 8'h0A;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

>>> rtl/pngce_in_stage.sv
// Input register stage that holds one accepted byte until the parser takes it.
`default_nettype none
module pngce_in_stage
	import pngce_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic       out_free,
	output logic            take,
	output byte_item_t      item
);

	logic       valid_s1;
	byte_item_t item_s1;

	assign take     = valid_s1 && (!item_s1.last || out_free);
	assign in_ready = !valid_s1 || take;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.data <= data_byte;
			item_s1.last <= last_byte;
		end
	end

endmodule
`default_nettype wire

>>> rtl/pngce_parser.sv
// Chunk envelope parser: stream state, limit register and status decision.
`default_nettype none
module pngce_parser
	import pngce_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        take,
	input  wire byte_item_t  item,
	output result_t          res
);

	logic [31:0] max_chunks_q;
	phase_t      phase_q, phase_n;
	logic [3:0]  hpos_q, hpos_n;
	logic [31:0] len_q, len_n;
	logic [31:0] tag_q, tag_n;
	logic [31:0] skip_q, skip_n;
	logic [31:0] seen_q, seen_n;
	logic [2:0]  err_q, err_n;
	logic        finish;
	logic [31:0] seen_inc;

	assign seen_inc = (seen_q == '1) ? seen_q : seen_q + 32'd1;

	always_comb begin
		phase_n = phase_q;
		hpos_n  = hpos_q;
		len_n   = len_q;
		tag_n   = tag_q;
		skip_n  = skip_q;
		seen_n  = seen_q;
		err_n   = err_q;
		finish  = 1'b0;
		case (phase_q)
			PH_SIG: begin
				if (item.data != sig_byte(hpos_q[2:0])) begin
					err_n   = ST_BAD_SIG;
					phase_n = PH_ERR;
				end else if (hpos_q[2:0] == SIG_LAST_POS) begin
					phase_n = PH_HEAD;
					hpos_n  = '0;
				end else begin
					hpos_n = hpos_q + 4'd1;
				end
			end
			PH_HEAD: begin
				if (hpos_q < HDR_LEN_END) begin
					len_n = {len_q[23:0], item.data};
				end else if (hpos_q < HDR_TAG_END) begin
					tag_n = {tag_q[23:0], item.data};
				end
				hpos_n = hpos_q + 4'd1;
				if (hpos_q == HDR_LAST_POS) begin
					seen_n = seen_inc;
					if (seen_q >= max_chunks_q) begin
						err_n   = ST_TOO_MANY;
						phase_n = PH_ERR;
					end else if (len_q == '0) begin
						finish = 1'b1;
					end else begin
						skip_n  = len_q;
						phase_n = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				skip_n = skip_q - 32'd1;
				if (skip_q == 32'd1) begin
					finish = 1'b1;
				end
			end
			PH_DONE: begin
				err_n   = ST_IEND_BAD;
				phase_n = PH_ERR;
			end
			default: begin
			end
		endcase

		if (finish) begin
			if (tag_q == TAG_IEND) begin
				if (len_q != '0) begin
					err_n   = ST_IEND_BAD;
					phase_n = PH_ERR;
				end else begin
					phase_n = PH_DONE;
				end
			end else begin
				phase_n = PH_HEAD;
				hpos_n  = '0;
				len_n   = '0;
				tag_n   = '0;
			end
		end

		res.chunk_count = seen_n;
		case (phase_n)
			PH_SIG:  res.status = ST_BAD_SIG;
			PH_HEAD: res.status = (hpos_n == '0) ? ST_IEND_MISS : ST_TRUNC_ENV;
			PH_SKIP: res.status = ST_TRUNC_PAY;
			PH_DONE: res.status = ST_OK;
			default: res.status = err_n;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunks_q <= MAX_CHUNKS_RESET;
		end else if (cfg_we) begin
			max_chunks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG;
			hpos_q  <= '0;
			len_q   <= '0;
			tag_q   <= '0;
			skip_q  <= '0;
			seen_q  <= '0;
			err_q   <= ST_OK;
		end else if (take) begin
			if (item.last) begin
				phase_q <= PH_SIG;
				hpos_q  <= '0;
				len_q   <= '0;
				tag_q   <= '0;
				skip_q  <= '0;
				seen_q  <= '0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= phase_n;
				hpos_q  <= hpos_n;
				len_q   <= len_n;
				tag_q   <= tag_n;
				skip_q  <= skip_n;
				seen_q  <= seen_n;
				err_q   <= err_n;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/pngce_out_stage.sv
// Result register that holds one status transaction until the receiver takes it.
`default_nettype none
module pngce_out_stage
	import pngce_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res,
	output logic         out_free,
	output logic         out_valid,
	input  wire logic    out_ready,
	output logic [2:0]   status,
	output logic [31:0]  chunk_count
);

	logic    valid_q;
	result_t res_q;

	assign out_free    = !valid_q || out_ready;
	assign out_valid   = valid_q;
	assign status      = res_q.status;
	assign chunk_count = res_q.chunk_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

>>> rtl/png_chunk_envelope_checker.sv
// Top level of the PNG chunk envelope checker.
// The input channel (in_valid, in_ready, data_byte, last_byte) takes one byte of
// an encoded PNG file per transaction; last_byte marks the final byte of a file.
// Only the final byte produces an output transaction (out_valid, out_ready,
// status, chunk_count); the block then starts over for the next file.
// Each byte is registered on acceptance in the input register; the parser works
// on it combinationally, and the result of a final byte is registered in the
// result register. One byte is taken per cycle, set by the single parser stage
// between the input register and the result register, while no final byte waits.
// If the receiver stalls, the result waits in the result register; bytes that
// are not final keep flowing, and a further final byte waits in the input
// register, which drops in_ready, until the result register is taken.
// The user must write the limit max_chunks (cfg_we, cfg_wdata) only while idle;
// the block does not enforce it. Reset clears the stream state, limit set to 1024.
`default_nettype none
module png_chunk_envelope_checker
	import pngce_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [31:0]      chunk_count,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);

	logic       out_free;
	logic       take;
	byte_item_t item;
	result_t    res;

	pngce_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_free  (out_free),
		.take      (take),
		.item      (item)
	);

	pngce_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.item      (item),
		.res       (res)
	);

	pngce_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (take && item.last),
		.res         (res),
		.out_free    (out_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.chunk_count (chunk_count)
	);

endmodule
`default_nettype wire

>>> rtl/pngce_checker.sv
// Port-level assertion checker for the PNG chunk envelope checker and its bind.
`default_nettype none
`include "png_chunk_envelope_checker_defines.svh"
module pngce_checker
	import pngce_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [31:0] chunk_count
);

	`PCE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`PCE_ASSERT_SAME(a_status_code, clk, arst_n, out_valid, status <= ST_IEND_MISS)
	`PCE_ASSERT_SAME(a_bad_sig_no_chunks, clk, arst_n, out_valid && (status == ST_BAD_SIG), chunk_count == '0)
	`PCE_ASSERT_SAME(a_limit_counted, clk, arst_n, out_valid && (status == ST_TOO_MANY), chunk_count != '0)

endmodule

bind png_chunk_envelope_checker pngce_checker u_pngce_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.chunk_count (chunk_count)
);
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench that streams PNG files into the chunk envelope checker and predicts each status.
`timescale 1ns / 1ps
module testbench;
	import pngce_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam logic [7:0] PNG_MAGIC [8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};

	typedef struct packed {
		logic [7:0]  data;
		logic        fin;
		logic        typed;
		logic [2:0]  status;
		logic [31:0] chunk_count;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [31:0] chunk_count;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	phase_t      prs_phase;
	logic [3:0]  prs_pos;
	logic [31:0] prs_len;
	logic [31:0] prs_tag;
	logic [32:0] prs_skip;
	logic [31:0] prs_count;
	logic [2:0]  prs_err;
	logic [31:0] limit_mirror;

	result_t     pending_status [$];
	logic [7:0]  file_bytes [$];
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          mismatches = 0;
	bit          hold_wanted = 1'b0;

	directed_row_t directed_rows [23] = '{
		'{8'h00, 1'b1, 1'b1, ST_BAD_SIG, 32'd0},
		'{8'h89, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'hFF, 1'b1, 1'b1, ST_BAD_SIG, 32'd0},
		'{8'h89, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h50, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h4E, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h47, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h0D, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h0A, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h1A, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h0A, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h49, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h45, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h4E, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h44, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'hAE, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h42, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h60, 1'b0, 1'b0, ST_OK, 32'd0},
		'{8'h82, 1'b1, 1'b1, ST_OK, 32'd1}
	};

	png_chunk_envelope_checker i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.chunk_count (chunk_count),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	function automatic void restart_stream();
		prs_phase = PH_SIG;
		prs_pos   = '0;
		prs_len   = '0;
		prs_tag   = '0;
		prs_skip  = '0;
		prs_count = '0;
		prs_err   = ST_OK;
	endfunction

	function automatic void latch_fault(input logic [2:0] code);
		prs_err   = code;
		prs_phase = PH_ERR;
	endfunction

	function automatic void close_chunk();
		if (prs_tag == TAG_IEND) begin
			if (prs_len != '0)
				latch_fault(ST_IEND_BAD);
			else
				prs_phase = PH_DONE;
		end else begin
			prs_phase = PH_HEAD;
			prs_pos   = '0;
			prs_len   = '0;
			prs_tag   = '0;
		end
	endfunction

	function automatic void open_chunk();
		logic [32:0] next_count;
		next_count = {1'b0, prs_count} + 33'd1;
		prs_count = next_count[32] ? '1 : next_count[31:0];
		if (next_count > {1'b0, limit_mirror}) begin
			latch_fault(ST_TOO_MANY);
		end else if (prs_len == '0) begin
			close_chunk();
		end else begin
			prs_skip  = {1'b0, prs_len};
			prs_phase = PH_SKIP;
		end
	endfunction

	function automatic bit parse_byte(input logic [7:0] b, input logic fin, output result_t res);
		res = '0;
		case (prs_phase)
			PH_SIG: begin
				if (b != PNG_MAGIC[prs_pos[2:0]]) begin
					latch_fault(ST_BAD_SIG);
				end else if (prs_pos[2:0] == SIG_LAST_POS) begin
					prs_phase = PH_HEAD;
					prs_pos   = '0;
				end else begin
					prs_pos++;
				end
			end
			PH_HEAD: begin
				if (prs_pos < HDR_LEN_END)
					prs_len = {prs_len[23:0], b};
				else if (prs_pos < HDR_TAG_END)
					prs_tag = {prs_tag[23:0], b};
				prs_pos++;
				if (prs_pos > HDR_LAST_POS)
					open_chunk();
			end
			PH_SKIP: begin
				if (prs_skip != '0)
					prs_skip--;
				if (prs_skip == '0)
					close_chunk();
			end
			PH_DONE: latch_fault(ST_IEND_BAD);
			default: ;
		endcase
		if (!fin)
			return 1'b0;
		case (prs_phase)
			PH_SIG:  res.status = ST_BAD_SIG;
			PH_HEAD: res.status = (prs_pos == '0) ? ST_IEND_MISS : ST_TRUNC_ENV;
			PH_SKIP: res.status = ST_TRUNC_PAY;
			PH_DONE: res.status = ST_OK;
			default: res.status = prs_err;
		endcase
		res.chunk_count = prs_count;
		restart_stream();
		return 1'b1;
	endfunction

	function automatic void push_word(input logic [31:0] w);
		for (int k = 3; k >= 0; k--)
			file_bytes.push_back(w[8*k +: 8]);
	endfunction

	function automatic void push_noise(input int unsigned n);
		repeat (n) file_bytes.push_back(8'($urandom));
	endfunction

	// Well-formed files with random chunks for about half of the calls, the rest broken or plain noise.
	function automatic void make_file();
		int unsigned kind;
		int unsigned ending;
		int unsigned chunks;
		int unsigned plen;
		int unsigned cut;
		logic [31:0] tag;
		file_bytes.delete();
		kind = $urandom_range(99);
		if (kind < 10) begin
			push_noise($urandom_range(1, 12));
			return;
		end
		for (int k = 0; k < 8; k++)
			file_bytes.push_back(PNG_MAGIC[k]);
		if (kind < 16)
			file_bytes[$urandom_range(7)] ^= 8'(1 << $urandom_range(7));
		chunks = $urandom_range(3);
		for (int c = 0; c < chunks; c++) begin
			plen = ($urandom_range(39) == 0) ? $urandom_range(200) : $urandom_range(6);
			tag = $urandom;
			if (tag == TAG_IEND)
				tag[0] = ~tag[0];
			push_word(plen);
			push_word(tag);
			push_noise(plen + 4);
		end
		ending = $urandom_range(99);
		if (ending < 82) begin
			plen = (ending >= 70 && ending < 76) ? $urandom_range(1, 4) : 0;
			push_word(plen);
			push_word(TAG_IEND);
			push_noise(plen + 4);
			if (ending >= 76)
				push_noise($urandom_range(1, 3));
		end else if (ending < 92) begin
			push_word($urandom);
			push_word($urandom);
			push_noise($urandom_range(1, 8));
		end
		if ($urandom_range(99) < 15) begin
			cut = $urandom_range(1, file_bytes.size() - 1);
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
			input result_t typed_res);
		result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (!in_ready);
		if (parse_byte(b, fin, predicted))
			pending_status.push_back(typed ? typed_res : predicted);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [31:0] limit, input int sidle, input int rstall,
			input int unsigned budget, input bit squeeze);
		int unsigned sent;
		sent = 0;
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_mirror   = limit;
		send_idle_pct  = sidle;
		recv_stall_pct = rstall;
		if (squeeze) begin
			// One-byte files pile up behind a receiver that holds off for a long stretch.
			hold_wanted = 1'b1;
			repeat (24) send_byte(8'($urandom), 1'b1, 1'b0, '0);
		end
		while (sent < budget) begin
			make_file();
			foreach (file_bytes[k])
				send_byte(file_bytes[k], k == file_bytes.size() - 1, 1'b0, '0);
			sent += file_bytes.size();
		end
	endtask

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction: status %0d chunk_count %0d",
					status, chunk_count));
			end else begin
				want = pending_status.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
				if (chunk_count !== want.chunk_count)
					report_mismatch($sformatf("chunk_count %0d, predicted %0d",
						chunk_count, want.chunk_count));
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		data_byte <= '0;
		last_byte <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		limit_mirror = MAX_CHUNKS_RESET;
		restart_stream();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[k])
			send_byte(directed_rows[k].data, directed_rows[k].fin, directed_rows[k].typed,
				result_t'({directed_rows[k].status, directed_rows[k].chunk_count}));
		run_phase(MAX_CHUNKS_RESET, 0, 0, 270, 1'b0);
		run_phase(32'd1, 47, 0, 270, 1'b0);
		run_phase(32'hFFFF_FFFF, 0, 47, 270, 1'b0);
		run_phase(32'd3, 24, 24, 270, 1'b0);
		run_phase(32'd2, 0, 0, 270, 1'b1);
		run_phase(32'd7, 24, 24, 270, 1'b0);
		settle();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#(4_000_000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/pngce_pkg.sv
rtl/pngce_in_stage.sv
rtl/pngce_parser.sv
rtl/pngce_out_stage.sv
rtl/png_chunk_envelope_checker.sv
rtl/pngce_checker.sv
test/testbench.sv
